[rtl/core/mi_pkg.sv]
package mi_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned COF_W  = 65;
    localparam int unsigned TERM_W = 97;
    localparam int unsigned DET_W  = 98;
    localparam int unsigned DIV_W  = 97;
    localparam int unsigned NUM_W  = 128;
    localparam int unsigned QUO_W  = 32;
    localparam int unsigned N_ENT  = 9;
    localparam int unsigned FRAC_BITS_DEF = 16;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [DIV_W-1:0]         dmag_t;
    typedef logic [PROD_W-1:0]        cmag_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [QUO_W-1:0] low;
        logic             neg;
        logic             ovf;
    } mi_lane_t;

endpackage

[rtl/core/mi_cofactor.sv]
module mi_cofactor (
    input  logic               aclk,
    input  logic [1:0]         en,
    input  mi_pkg::data_t      a_in [mi_pkg::N_ENT],
    output mi_pkg::data_t      row_out [3],
    output mi_pkg::cof_t       cof_out [mi_pkg::N_ENT]
);
    import mi_pkg::*;

    localparam int IA [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
    localparam int IB [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

    prod_t prod_reg [18];
    data_t row0_reg [3];
    data_t row1_reg [3];
    cof_t  cof_reg  [N_ENT];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int k = 0; k < 18; k++) begin
                prod_reg[k] <= PROD_W'(a_in[IA[k]]) * PROD_W'(a_in[IB[k]]);
            end
            for (int k = 0; k < 3; k++) begin
                row0_reg[k] <= a_in[k];
            end
        end
        if (en[1]) begin
            for (int k = 0; k < N_ENT; k++) begin
                cof_reg[k] <= COF_W'(prod_reg[2*k]) - COF_W'(prod_reg[2*k+1]);
            end
            row1_reg <= row0_reg;
        end
    end

    assign row_out = row1_reg;
    assign cof_out = cof_reg;

endmodule

[rtl/core/mi_det.sv]
module mi_det (
    input  logic               aclk,
    input  logic [3:0]         en,
    input  mi_pkg::data_t      row_in [3],
    input  mi_pkg::cof_t       cof_in [mi_pkg::N_ENT],
    output mi_pkg::dmag_t      dmag_out,
    output logic               dneg_out,
    output logic               zero_out,
    output mi_pkg::cmag_t      cmag_out [mi_pkg::N_ENT],
    output logic [mi_pkg::N_ENT-1:0] cneg_out
);
    import mi_pkg::*;

    cof_t  plo_reg [3];
    cof_t  phi_reg [3];
    cof_t  cof2_reg [N_ENT];
    term_t term_reg [3];
    cof_t  cof3_reg [N_ENT];
    det_t  det_reg;
    cof_t  cof4_reg [N_ENT];
    dmag_t dmag_reg;
    logic  dneg_reg;
    logic  zero_reg;
    cmag_t cmag_reg [N_ENT];
    logic [N_ENT-1:0] cneg_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                plo_reg[k] <= COF_W'(row_in[k]) * $signed({33'b0, cof_in[k][31:0]});
                phi_reg[k] <= COF_W'(row_in[k]) * COF_W'($signed(cof_in[k][64:32]));
            end
            cof2_reg <= cof_in;
        end
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                term_reg[k] <= (TERM_W'(phi_reg[k]) <<< 32) + TERM_W'(plo_reg[k]);
            end
            cof3_reg <= cof2_reg;
        end
        if (en[2]) begin
            det_reg  <= DET_W'(term_reg[0]) + DET_W'(term_reg[1]) + DET_W'(term_reg[2]);
            cof4_reg <= cof3_reg;
        end
        if (en[3]) begin
            dneg_reg <= det_reg[DET_W-1];
            zero_reg <= (det_reg == '0);
            dmag_reg <= det_reg[DET_W-1] ? DIV_W'(-det_reg) : DIV_W'(det_reg);
            for (int k = 0; k < N_ENT; k++) begin
                cneg_reg[k] <= cof4_reg[k][COF_W-1];
                cmag_reg[k] <= cof4_reg[k][COF_W-1] ? PROD_W'(-cof4_reg[k])
                                                    : PROD_W'(cof4_reg[k]);
            end
        end
    end

    assign dmag_out = dmag_reg;
    assign dneg_out = dneg_reg;
    assign zero_out = zero_reg;
    assign cmag_out = cmag_reg;
    assign cneg_out = cneg_reg;

endmodule

[rtl/core/mi_div_stage.sv]
module mi_div_stage (
    input  logic               aclk,
    input  logic               en,
    input  mi_pkg::mi_lane_t   lane_in [mi_pkg::N_ENT],
    input  mi_pkg::dmag_t      dmag_in,
    input  logic               zero_in,
    output mi_pkg::mi_lane_t   lane_out [mi_pkg::N_ENT],
    output mi_pkg::dmag_t      dmag_out,
    output logic               zero_out
);
    import mi_pkg::*;

    mi_lane_t lane_reg [N_ENT];
    dmag_t    dmag_reg;
    logic     zero_reg;
    mi_lane_t lane_next [N_ENT];

    // one restoring step per lane
    always_comb begin
        logic [DIV_W:0] t;
        logic           ge;
        for (int k = 0; k < N_ENT; k++) begin
            t  = {lane_in[k].rem, lane_in[k].low[QUO_W-1]};
            ge = (t >= {1'b0, dmag_in});
            lane_next[k]     = lane_in[k];
            lane_next[k].rem = ge ? DIV_W'(t - {1'b0, dmag_in}) : DIV_W'(t);
            lane_next[k].quo = {lane_in[k].quo[QUO_W-2:0], ge};
            lane_next[k].low = {lane_in[k].low[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
            dmag_reg <= dmag_in;
            zero_reg <= zero_in;
        end
    end

    assign lane_out = lane_reg;
    assign dmag_out = dmag_reg;
    assign zero_out = zero_reg;

endmodule

[rtl/core/matrix3x3_inverse_top.sv]
// channel | ports                    | direction | content
// s_      | s_valid s_ready s_m00..22 | in        | 3x3 matrix, signed fixed point
// m_      | m_valid m_ready m_inv00..22 m_singular | out | inverse, singular flag
//
// 40 register stages: products, cofactors, determinant (4), divider setup,
// 32 restoring divider steps (nine lanes), round/saturate. One request per
// cycle sustained while m_ready stays high.
// aresetn (synchronous, active low) clears the stage valid bits only.
// A stall holds only the stages that are full behind it; bubbles close up.
module matrix3x3_inverse_top #(
    parameter int unsigned FRAC_BITS = mi_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_m00,
    input  logic signed [31:0] s_m01,
    input  logic signed [31:0] s_m02,
    input  logic signed [31:0] s_m10,
    input  logic signed [31:0] s_m11,
    input  logic signed [31:0] s_m12,
    input  logic signed [31:0] s_m20,
    input  logic signed [31:0] s_m21,
    input  logic signed [31:0] s_m22,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_inv00,
    output logic signed [31:0] m_inv01,
    output logic signed [31:0] m_inv02,
    output logic signed [31:0] m_inv10,
    output logic signed [31:0] m_inv11,
    output logic signed [31:0] m_inv12,
    output logic signed [31:0] m_inv20,
    output logic signed [31:0] m_inv21,
    output logic signed [31:0] m_inv22,
    output logic               m_singular
);
    import mi_pkg::*;

    localparam int unsigned N_STEP = QUO_W;
    localparam int unsigned N_STG  = 8 + N_STEP;
    localparam int unsigned SH     = 2 * FRAC_BITS;

    logic [N_STG-1:0] valid_reg;
    logic [N_STG-1:0] en;

    data_t a_in [N_ENT];
    data_t row  [3];
    cof_t  cof  [N_ENT];
    dmag_t dmag;
    logic  dneg;
    logic  zero;
    cmag_t cmag [N_ENT];
    logic [N_ENT-1:0] cneg;

    mi_lane_t lane_reg [N_ENT];
    dmag_t    dmag_reg;
    logic     zero_reg;
    mi_lane_t lane_s [N_STEP+1][N_ENT];
    dmag_t    dmag_s [N_STEP+1];
    logic     zero_s [N_STEP+1];

    logic [QUO_W-1:0] res_reg [N_ENT];
    logic             sing_reg;
    logic [QUO_W-1:0] res_next [N_ENT];

    assign a_in = '{s_m00, s_m01, s_m02, s_m10, s_m11, s_m12, s_m20, s_m21, s_m22};

    always_comb begin
        logic rdy;
        rdy = m_ready;
        for (int k = N_STG - 1; k >= 0; k--) begin
            rdy   = !valid_reg[k] || rdy;
            en[k] = rdy;
        end
    end

    assign s_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    mi_cofactor u_cof (
        .aclk    (aclk),
        .en      (en[1:0]),
        .a_in    (a_in),
        .row_out (row),
        .cof_out (cof)
    );

    mi_det u_det (
        .aclk     (aclk),
        .en       (en[5:2]),
        .row_in   (row),
        .cof_in   (cof),
        .dmag_out (dmag),
        .dneg_out (dneg),
        .zero_out (zero),
        .cmag_out (cmag),
        .cneg_out (cneg)
    );

    // divider setup; transposed cofactor order
    localparam int PICK [N_ENT] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            for (int k = 0; k < N_ENT; k++) begin
                logic [NUM_W-1:0] num;
                num = NUM_W'(cmag[PICK[k]]) << SH;
                lane_reg[k].ovf <= ({1'b0, num} >= ((NUM_W+1)'(dmag) << QUO_W));
                lane_reg[k].rem <= DIV_W'(num[NUM_W-1:QUO_W]);
                lane_reg[k].low <= num[QUO_W-1:0];
                lane_reg[k].quo <= '0;
                lane_reg[k].neg <= cneg[PICK[k]] ^ dneg;
            end
            dmag_reg <= dmag;
            zero_reg <= zero;
        end
    end

    assign lane_s[0] = lane_reg;
    assign dmag_s[0] = dmag_reg;
    assign zero_s[0] = zero_reg;

    for (genvar g = 0; g < N_STEP; g++) begin : g_step
        mi_div_stage u_step (
            .aclk     (aclk),
            .en       (en[7+g]),
            .lane_in  (lane_s[g]),
            .dmag_in  (dmag_s[g]),
            .zero_in  (zero_s[g]),
            .lane_out (lane_s[g+1]),
            .dmag_out (dmag_s[g+1]),
            .zero_out (zero_s[g+1])
        );
    end

    always_comb begin
        logic [QUO_W:0] q1;
        logic           sat;
        for (int k = 0; k < N_ENT; k++) begin
            q1  = (QUO_W+1)'(lane_s[N_STEP][k].quo)
                + (QUO_W+1)'({lane_s[N_STEP][k].rem, 1'b0} >= {1'b0, dmag_s[N_STEP]});
            sat = lane_s[N_STEP][k].ovf || (q1[QUO_W:QUO_W-1] != 2'b00);
            if (zero_s[N_STEP]) begin
                res_next[k] = '0;
            end else if (lane_s[N_STEP][k].neg) begin
                res_next[k] = sat ? {1'b1, {(QUO_W-1){1'b0}}} : QUO_W'(-q1);
            end else begin
                res_next[k] = sat ? {1'b0, {(QUO_W-1){1'b1}}} : q1[QUO_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[N_STG-1]) begin
            res_reg  <= res_next;
            sing_reg <= zero_s[N_STEP];
        end
    end

    assign m_valid    = valid_reg[N_STG-1];
    assign m_inv00    = res_reg[0];
    assign m_inv01    = res_reg[1];
    assign m_inv02    = res_reg[2];
    assign m_inv10    = res_reg[3];
    assign m_inv11    = res_reg[4];
    assign m_inv12    = res_reg[5];
    assign m_inv20    = res_reg[6];
    assign m_inv21    = res_reg[7];
    assign m_inv22    = res_reg[8];
    assign m_singular = sing_reg;

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mi_pkg::*;

    localparam int F = FRAC_BITS_DEF;
    localparam int N_ITEMS = 1950;
    localparam int HOLD_LEN = 400;

    typedef struct {
        data_t m[9];
    } matrix_t;

    typedef struct {
        data_t inv[9];
        logic  sing;
    } inverse_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    data_t s_m[9];
    logic m_valid;
    logic m_ready = 1'b0;
    data_t m_inv[9];
    logic m_singular;

    matrix_t pending_mats[$];
    inverse_t expected_invs[$];
    int errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_singular = 0;
    int n_saturated = 0;
    int cycle = 0;
    bit s_fire = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always #5 aclk = ~aclk;

    matrix3x3_inverse_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m[0]), .s_m01(s_m[1]), .s_m02(s_m[2]),
        .s_m10(s_m[3]), .s_m11(s_m[4]), .s_m12(s_m[5]),
        .s_m20(s_m[6]), .s_m21(s_m[7]), .s_m22(s_m[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_inv00(m_inv[0]), .m_inv01(m_inv[1]), .m_inv02(m_inv[2]),
        .m_inv10(m_inv[3]), .m_inv11(m_inv[4]), .m_inv12(m_inv[5]),
        .m_inv20(m_inv[6]), .m_inv21(m_inv[7]), .m_inv22(m_inv[8]),
        .m_singular(m_singular)
    );

    function automatic inverse_t invert(matrix_t a);
        logic signed [127:0] x[9];
        logic signed [127:0] c[9];
        logic signed [127:0] det;
        logic signed [127:0] cv;
        logic [127:0] dmag, num, q, r;
        logic neg;
        inverse_t res;
        int pick[9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};
        for (int i = 0; i < 9; i++) x[i] = a.m[i];
        c[0] = x[4] * x[8] - x[5] * x[7];
        c[1] = x[5] * x[6] - x[3] * x[8];
        c[2] = x[3] * x[7] - x[4] * x[6];
        c[3] = x[2] * x[7] - x[1] * x[8];
        c[4] = x[0] * x[8] - x[2] * x[6];
        c[5] = x[1] * x[6] - x[0] * x[7];
        c[6] = x[1] * x[5] - x[2] * x[4];
        c[7] = x[2] * x[3] - x[0] * x[5];
        c[8] = x[0] * x[4] - x[1] * x[3];
        det = x[0] * c[0] + x[1] * c[1] + x[2] * c[2];
        res.sing = (det == 0);
        for (int i = 0; i < 9; i++) res.inv[i] = '0;
        if (res.sing) return res;
        dmag = (det < 0) ? -det : det;
        for (int i = 0; i < 9; i++) begin
            cv = c[pick[i]];
            num = (cv < 0) ? -cv : cv;
            num = num << (2 * F);
            q = num / dmag;
            r = num % dmag;
            if ((r << 1) >= dmag) q = q + 1;
            neg = (cv < 0) != (det < 0);
            if (neg) begin
                if (q >= 128'h8000_0000) res.inv[i] = 32'h8000_0000;
                else res.inv[i] = -q[31:0];
            end else begin
                if (q > 128'h7FFF_FFFF) res.inv[i] = 32'h7FFF_FFFF;
                else res.inv[i] = q[31:0];
            end
        end
        return res;
    endfunction

    function automatic data_t near_unit(int span);
        return data_t'($urandom_range(0, 2 * span)) - data_t'(span);
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t a;
        int kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++) a.m[i] = near_unit(1 << (F + 2));
        if (kind < 20) begin
            for (int i = 0; i < 9; i++) a.m[i] = $urandom;
        end else if (kind < 35) begin
            case ($urandom_range(0, 2))
                0: for (int j = 0; j < 3; j++) a.m[6 + j] = a.m[j];
                1: for (int j = 0; j < 3; j++) a.m[3 * j] = '0;
                default: for (int j = 0; j < 3; j++) a.m[3 + j] = -a.m[j];
            endcase
        end else if (kind < 50) begin
            for (int i = 0; i < 9; i++)
                a.m[i] = (i % 4 == 0) ? near_unit(1 << (F + 3)) : near_unit(1 << (F - 4));
        end else if (kind < 60) begin
            for (int i = 0; i < 9; i++) a.m[i] = near_unit(4) <<< F;
        end else if (kind < 68) begin
            for (int i = 0; i < 9; i++) a.m[i] = near_unit(1 << 6);
        end
        return a;
    endfunction

    // stimulus
    initial begin
        matrix_t a;
        for (int k = 0; k < 22; k++) begin
            for (int i = 0; i < 9; i++) a.m[i] = '0;
            case (k)
                0: for (int i = 0; i < 9; i += 4) a.m[i] = 32'sd1 <<< F;
                1: ;
                2: for (int i = 0; i < 9; i++) a.m[i] = 32'h7FFF_FFFF;
                3: for (int i = 0; i < 9; i++) a.m[i] = 32'h8000_0000;
                4: for (int i = 0; i < 9; i += 4) a.m[i] = 32'h7FFF_FFFF;
                5: for (int i = 0; i < 9; i += 4) a.m[i] = 32'h8000_0000;
                6: for (int i = 0; i < 9; i += 4) a.m[i] = 32'sd1;
                7: for (int i = 0; i < 9; i += 4) a.m[i] = -32'sd1;
                8: for (int i = 0; i < 9; i += 4) a.m[i] = 32'sd3 <<< F;
                9: begin
                    a.m[0] = 32'sd2 <<< F; a.m[4] = 32'sd2 <<< F; a.m[8] = 32'sd1 <<< (F + 15);
                end
                10: begin
                    a.m[2] = 32'sd1 <<< F; a.m[4] = 32'sd1 <<< F; a.m[6] = 32'sd1 <<< F;
                end
                11: begin
                    a.m[0] = 32'h7FFF_FFFF; a.m[4] = 32'h8000_0000; a.m[8] = 32'h7FFF_FFFF;
                    a.m[1] = 32'h8000_0000; a.m[5] = 32'h7FFF_FFFF; a.m[6] = 32'h8000_0000;
                end
                12: for (int i = 0; i < 9; i++) a.m[i] = (i + 1) <<< F;
                13: for (int i = 0; i < 9; i++) a.m[i] = (i == 0) ? 32'h8000_0000 : 32'h5555_5555;
                14: for (int i = 0; i < 9; i++) a.m[i] = 32'hAAAA_AAAA ^ (i << 3);
                15: begin
                    a.m[0] = -(32'sd2 <<< F); a.m[4] = 32'sd1 <<< F; a.m[8] = 32'sd1 <<< F;
                    a.m[1] = 32'sd1 <<< F;
                end
                default: a = random_matrix();
            endcase
            pending_mats = {pending_mats, a};
        end
        for (int k = 0; k < N_ITEMS; k++) begin
            a = random_matrix();
            pending_mats = {pending_mats, a};
        end
    end

    // sender
    always @(negedge aclk) begin
        bit idle;
        idle = ($urandom_range(0, 99) < 18) && !(cycle > 600 && cycle < 1400);
        if (aresetn && (!s_valid || s_fire)) begin
            if (pending_mats.size() > 0 && !idle) begin
                matrix_t a;
                a = pending_mats.pop_front();
                for (int i = 0; i < 9; i++) s_m[i] <= a.m[i];
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && n_accepted > 200) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 18) || (cycle > 600 && cycle < 1400);
        end
    end

    // monitor
    always @(posedge aclk) begin
        inverse_t e;
        cycle <= cycle + 1;
        s_fire <= s_valid && s_ready && aresetn;
        if (aresetn && s_valid && s_ready) begin
            matrix_t a;
            for (int i = 0; i < 9; i++) a.m[i] = s_m[i];
            e = invert(a);
            expected_invs = {expected_invs, e};
            n_accepted <= n_accepted + 1;
            if (e.sing) n_singular <= n_singular + 1;
            for (int i = 0; i < 9; i++)
                if (e.inv[i] == 32'h7FFF_FFFF || e.inv[i] == 32'h8000_0000) begin
                    n_saturated <= n_saturated + 1;
                    break;
                end
        end
        if (aresetn && m_valid && m_ready) begin
            n_results <= n_results + 1;
            if (expected_invs.size() == 0) begin
                $display("%0t: unexpected result, nothing pending", $time);
                errors = errors + 1;
            end else begin
                e = expected_invs.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_inv[i] !== e.inv[i]) begin
                        $display("%0t: inv%0d%0d expected %h actual %h",
                                 $time, i / 3, i % 3, e.inv[i], m_inv[i]);
                        errors = errors + 1;
                    end
                if (m_singular !== e.sing) begin
                    $display("%0t: singular expected %b actual %b",
                             $time, e.sing, m_singular);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 9; i++) s_m[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_mats.size() == 0 && !s_valid);
        while (expected_invs.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Inverted %0d matrices, %0d singular, %0d with saturated entries.",
                 n_results, n_singular, n_saturated);
        if (errors == 0 && expected_invs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout waiting for results");
        $display("Simulation FAILED");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/mi_pkg.sv
rtl/core/mi_cofactor.sv
rtl/core/mi_det.sv
rtl/core/mi_div_stage.sv
rtl/core/matrix3x3_inverse_top.sv
test/tb.sv
